@@ design/btc_pkg.sv @@
// Shared types and constants for the box triangle clipper.
`timescale 1ns / 1ps
package btc_pkg;

	localparam int CoordW = 24;
	localparam int AxisW = 48;
	localparam int DistW = 42;
	localparam logic signed [DistW-1:0] EpsQ22 = 42'sd419430;
	localparam int EmitMax = 9;
	localparam int NumPlanes = 6;

	typedef logic signed [CoordW-1:0] coord_t;

	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} vert_t;

	typedef enum logic [1:0] {
		SIDE_F = 2'd0,
		SIDE_B = 2'd1,
		SIDE_O = 2'd2
	} side_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIST_RD,
		ST_DIST,
		ST_CHECK,
		ST_EDGE_RD,
		ST_EDGE,
		ST_DIV,
		ST_INTERP,
		ST_NEXT,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		REG_AXIS_A = 3'd0,
		REG_AXIS_B = 3'd1,
		REG_AXIS_C = 3'd2,
		REG_CD_A = 3'd3,
		REG_CD_B = 3'd4,
		REG_CD_C = 3'd5,
		REG_HALF = 3'd6
	} reg_idx_t;

endpackage

@@ design/box_triangle_clipper.sv @@
// Top level: oriented box triangle clipper with polygon memories.
`timescale 1ns / 1ps
// Usage
//   s_axis: one beat per triangle; tdata holds ax,ay,az,bx,by_coord,bz,cx,cy,cz
//   (24 bits each, ax lowest). m_axis: one beat per clipped vertex, tdata holds
//   out_x,out_y,out_z,vertex_index (lowest first), tlast marks the last vertex.
//   cfg_we/cfg_idx/cfg_data write the box registers; write them while idle.
// Operation
//   The polygon lives in two ping-pong memories (one read port each,
//   registered read). An accepted triangle is loaded into memory 0. Each of
//   six planes runs a distance pass and then an edge pass; each crossing
//   adds a serial divide and then an interpolation. A new triangle is taken
//   once the block is idle, even while the last vertex beat still waits in
//   the output register. Dropped triangles give no beat.
// Reset
//   arst_n clears the control and loads the default unit-cube registers.
//   A stalled m_axis holds its beat and the block waits.
module box_triangle_clipper #(
	parameter int POLY_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [215:0] s_axis_tdata,   // ax,ay,az,bx,by_coord,bz,cx,cy,cz
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [79:0] m_axis_tdata,    // out_x,out_y,out_z,vertex_index,pad
	output logic m_axis_tlast,
	input  logic cfg_we,
	input  logic [2:0] cfg_idx,
	input  logic [47:0] cfg_data
);
	import btc_pkg::*;

	localparam int IW = $clog2(POLY_DEPTH);
	localparam int CW = $clog2(POLY_DEPTH + 1);

	// configuration
	logic [AxisW-1:0] axis_q [3];
	logic signed [23:0] cd_q [3];
	logic [22:0] half_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q[0] <= 48'd16384;
			axis_q[1] <= 48'd1073741824;
			axis_q[2] <= 48'd70368744177664;
			cd_q[0] <= '0;
			cd_q[1] <= '0;
			cd_q[2] <= '0;
			half_q <= 23'd256;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_AXIS_A: axis_q[0] <= cfg_data;
				REG_AXIS_B: axis_q[1] <= cfg_data;
				REG_AXIS_C: axis_q[2] <= cfg_data;
				REG_CD_A: cd_q[0] <= cfg_data[23:0];
				REG_CD_B: cd_q[1] <= cfg_data[23:0];
				REG_CD_C: cd_q[2] <= cfg_data[23:0];
				REG_HALF: half_q <= cfg_data[22:0];
				default: ;
			endcase
		end
	end

	// control registers
	state_t state_q, state_d;
	logic [2:0] plane_q;
	logic bank_q;
	logic [CW-1:0] n_q, m_q;
	logic [IW-1:0] i_q;
	logic front_q;
	logic [3:0] emit_q;
	logic [1:0] ld_q;

	// side/dist memory of current polygon, read with the vertex memories
	logic signed [DistW-1:0] dist_mem [POLY_DEPTH];
	side_t side_mem [POLY_DEPTH];
	logic signed [DistW-1:0] dist_rd_q, d0_q;
	side_t side_rd_q, s0_q;

	// two vertex memories: read from bank_q, write the other (the input load writes mem0)
	vert_t mem0 [POLY_DEPTH];
	vert_t mem1 [POLY_DEPTH];
	logic [IW-1:0] rd_addr;
	logic rd_en;
	vert_t rd0_q, rd1_q, rd_data;
	logic wr_en, wr_bank;
	logic [IW-1:0] wr_addr;
	vert_t wr_data;

	always_ff @(posedge clk) begin
		if (wr_en && !wr_bank) mem0[wr_addr] <= wr_data;
		if (rd_en) rd0_q <= mem0[rd_addr];
	end
	always_ff @(posedge clk) begin
		if (wr_en && wr_bank) mem1[wr_addr] <= wr_data;
		if (rd_en) rd1_q <= mem1[rd_addr];
	end
	assign rd_data = bank_q ? rd1_q : rd0_q;

	// plane normal and distance
	logic [1:0] ax_sel;
	logic neg;
	logic signed [15:0] nx, ny, nz;
	logic signed [25:0] pd;
	logic signed [DistW-1:0] dq;
	always_comb begin
		ax_sel = plane_q[2:1];
		neg = plane_q[0];
		nx = axis_q[ax_sel][15:0];
		ny = axis_q[ax_sel][31:16];
		nz = axis_q[ax_sel][47:32];
		pd = neg ? (-26'(cd_q[ax_sel]) - 26'(half_q)) : (26'(cd_q[ax_sel]) - 26'(half_q));
		dq = DistW'(pd) <<< 14;
	end

	// dot product, one register after the products
	logic signed [39:0] px_s1, py_s1, pz_s1;
	logic signed [DistW-1:0] dot, dval;
	always_ff @(posedge clk) begin
		px_s1 <= rd_data.x * nx;
		py_s1 <= rd_data.y * ny;
		pz_s1 <= rd_data.z * nz;
	end
	always_comb begin
		dot = DistW'(px_s1) + DistW'(py_s1) + DistW'(pz_s1);
		dval = (neg ? -dot : dot) - dq;
	end

	// edge pass registers
	vert_t v0_q, v1_q;
	logic [IW-1:0] j_idx;
	logic signed [DistW-1:0] d0, d1;
	side_t s0, s1;
	logic [DistW-1:0] a_mag, b_mag;
	logic div_start, div_busy;
	logic [16:0] t_q17;
	logic [1:0] ip_q;
	logic [1:0] sub_q;

	assign j_idx = (CW'(i_q) + CW'(1) < n_q) ? i_q + IW'(1) : '0;
	// first end held from the earlier read, second end straight from the read register
	always_comb begin
		d0 = d0_q;
		d1 = dist_rd_q;
		s0 = s0_q;
		s1 = side_rd_q;
		a_mag = d0[DistW-1] ? DistW'(-d0) : DistW'(d0);
		b_mag = d1[DistW-1] ? DistW'(-d1) : DistW'(d1);
	end

	btc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(a_mag), .den({1'b0, a_mag} + {1'b0, b_mag}),
		.busy(div_busy), .quo(t_q17)
	);

	// interpolation, one coordinate at a time, x then y then z
	coord_t cv, cw_c;
	logic signed [24:0] diff;
	logic signed [42:0] prod_s1;
	logic signed [42:0] rnd;
	coord_t res;
	vert_t ivert_q;
	always_comb begin
		case (ip_q)
			2'd0: begin cv = v0_q.x; cw_c = v1_q.x; end
			2'd1: begin cv = v0_q.y; cw_c = v1_q.y; end
			default: begin cv = v0_q.z; cw_c = v1_q.z; end
		endcase
		diff = 25'(cw_c) - 25'(cv);
	end
	always_ff @(posedge clk) prod_s1 <= diff * $signed({1'b0, t_q17[15:0]});
	always_comb begin
		if (!prod_s1[42]) rnd = (prod_s1 + 43'sd32768) >>> 16;
		else rnd = -((-prod_s1 + 43'sd32768) >>> 16);
		res = cv + coord_t'(rnd);
	end

	// output register
	logic out_v_q, out_l_q;
	vert_t out_vert_q;
	logic [3:0] out_idx_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast = out_l_q;
	assign m_axis_tdata = {4'd0, out_idx_q, out_vert_q.z, out_vert_q.y, out_vert_q.x};
	assign s_axis_tready = (state_q == ST_IDLE);

	logic [3:0] emit_n;
	assign emit_n = (n_q > CW'(EmitMax)) ? 4'(EmitMax) : 4'(n_q);

	// next state
	always_comb begin
		state_d = state_q;
		rd_en = 1'b0;
		rd_addr = i_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: if (s_axis_tvalid) state_d = ST_LOAD;
			ST_LOAD: if (ld_q == 2'd2) state_d = ST_DIST_RD;
			ST_DIST_RD: begin rd_en = 1'b1; state_d = ST_DIST; end
			ST_DIST: state_d = (sub_q == 2'd1) ?
				((CW'(i_q) + CW'(1) == n_q) ? ST_CHECK : ST_DIST_RD) : ST_DIST;
			ST_CHECK: state_d = front_q ? ST_EDGE_RD : ST_IDLE;
			ST_EDGE_RD: begin rd_en = 1'b1; rd_addr = i_q; state_d = ST_EDGE; end
			ST_EDGE: begin
				if (sub_q == 2'd0) begin
					rd_en = 1'b1; rd_addr = j_idx; state_d = ST_EDGE;
				end else if (s0 != SIDE_O && s1 != SIDE_O && s0 != s1 &&
					(CW+1)'(m_q) + (CW+1)'(s0 != SIDE_B) < (CW+1)'(POLY_DEPTH)) begin
					div_start = 1'b1; state_d = ST_DIV;
				end else state_d = ST_NEXT;
			end
			ST_DIV: if (!div_busy) state_d = ST_INTERP;
			ST_INTERP: if (ip_q == 2'd2 && sub_q == 2'd1) state_d = ST_NEXT;
			ST_NEXT: begin
				if (CW'(i_q) + CW'(1) == n_q) begin
					if (plane_q == 3'(NumPlanes - 1))
						state_d = (m_q < CW'(3)) ? ST_IDLE : ST_EMIT_RD;
					else state_d = ST_DIST_RD;
				end else state_d = ST_EDGE_RD;
			end
			ST_EMIT_RD: begin
				if (!out_v_q || m_axis_tready) begin
					rd_en = 1'b1; rd_addr = IW'(emit_q); state_d = ST_EMIT;
				end
			end
			ST_EMIT: state_d = (emit_q + 4'd1 == emit_n) ? ST_IDLE : ST_EMIT_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	// input triangle register and the vertex picked for each load cycle
	logic [215:0] in_q;
	vert_t ld_vert;
	always_comb begin
		case (ld_q)
			2'd0: ld_vert = '{z: in_q[71:48], y: in_q[47:24], x: in_q[23:0]};
			2'd1: ld_vert = '{z: in_q[143:120], y: in_q[119:96], x: in_q[95:72]};
			default: ld_vert = '{z: in_q[215:192], y: in_q[191:168], x: in_q[167:144]};
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) in_q <= s_axis_tdata;
	end

	// writes: input load, kept vertices, crossings
	always_comb begin
		wr_en = 1'b0;
		wr_bank = ~bank_q;
		wr_addr = IW'(m_q);
		wr_data = v0_q;
		if (state_q == ST_LOAD) begin
			wr_en = 1'b1;
			wr_bank = 1'b0;
			wr_addr = IW'(ld_q);
			wr_data = ld_vert;
		end else if (state_q == ST_EDGE && sub_q == 2'd1 && s0 != SIDE_B &&
			m_q < CW'(POLY_DEPTH)) begin
			wr_en = 1'b1;
		end else if (state_q == ST_INTERP && ip_q == 2'd2 && sub_q == 2'd1) begin
			wr_en = 1'b1;
			wr_data = '{z: res, y: ivert_q.y, x: ivert_q.x};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			plane_q <= '0;
			bank_q <= 1'b0;
			n_q <= '0;
			m_q <= '0;
			i_q <= '0;
			front_q <= 1'b0;
			emit_q <= '0;
			ip_q <= '0;
			sub_q <= '0;
			ld_q <= '0;
			out_v_q <= 1'b0;
			out_l_q <= 1'b0;
			out_vert_q <= '0;
			out_idx_q <= '0;
			v0_q <= '0;
			v1_q <= '0;
			ivert_q <= '0;
			d0_q <= '0;
			s0_q <= SIDE_O;
		end else begin
			// beat register: loaded on emit, cleared once taken
			if (state_q == ST_EMIT) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_axis_tvalid) begin
					ld_q <= 2'd0; plane_q <= '0; bank_q <= 1'b0; n_q <= CW'(3);
					i_q <= '0; front_q <= 1'b0; sub_q <= '0;
				end
				ST_LOAD: ld_q <= ld_q + 2'd1;
				ST_DIST_RD: sub_q <= 2'd0;
				ST_DIST: begin
					if (sub_q == 2'd0) sub_q <= 2'd2;
					else if (sub_q == 2'd2) sub_q <= 2'd1;
					else begin
						sub_q <= 2'd0;
						if (CW'(i_q) + CW'(1) == n_q) begin i_q <= '0; m_q <= '0; end
						else i_q <= i_q + IW'(1);
					end
				end
				ST_CHECK: sub_q <= 2'd0;
				ST_EDGE_RD: sub_q <= 2'd0;
				ST_EDGE: begin
					if (sub_q == 2'd0) begin
						v0_q <= rd_data; d0_q <= dist_rd_q; s0_q <= side_rd_q;
						sub_q <= 2'd1;
					end else begin
						v1_q <= rd_data;
						if (s0 != SIDE_B && m_q < CW'(POLY_DEPTH)) m_q <= m_q + CW'(1);
						ip_q <= '0; sub_q <= 2'd0;
					end
				end
				ST_INTERP: begin
					if (sub_q == 2'd0) sub_q <= 2'd1;
					else begin
						sub_q <= 2'd0;
						if (ip_q == 2'd0) ivert_q.x <= res;
						if (ip_q == 2'd1) ivert_q.y <= res;
						if (ip_q == 2'd2) m_q <= m_q + CW'(1);
						else ip_q <= ip_q + 2'd1;
					end
				end
				ST_NEXT: begin
					if (CW'(i_q) + CW'(1) == n_q) begin
						i_q <= '0; n_q <= m_q; bank_q <= ~bank_q;
						plane_q <= plane_q + 3'd1; front_q <= 1'b0; emit_q <= '0;
					end else i_q <= i_q + IW'(1);
				end
				ST_EMIT: begin
					out_vert_q <= rd_data;
					out_idx_q <= emit_q;
					out_l_q <= (emit_q + 4'd1 == emit_n);
					emit_q <= emit_q + 4'd1;
				end
				default: ;
			endcase
			// distance classification lands once the read and product registers are loaded
			if (state_q == ST_DIST && sub_q == 2'd1 && dval > EpsQ22) front_q <= 1'b1;
			state_q <= state_d;
		end
	end

	// distance store written when the product register is valid, read with the vertices
	always_ff @(posedge clk) begin
		if (state_q == ST_DIST && sub_q == 2'd1) begin
			dist_mem[i_q] <= dval;
			side_mem[i_q] <= (dval > EpsQ22) ? SIDE_F :
				(dval < -EpsQ22) ? SIDE_B : SIDE_O;
		end
		if (rd_en) begin
			dist_rd_q <= dist_mem[rd_addr];
			side_rd_q <= side_mem[rd_addr];
		end
	end
endmodule

@@ design/btc_div.sv @@
// Restoring divider for the crossing parameter t = floor(a*2^16/(a+b)).
`timescale 1ns / 1ps
module btc_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [btc_pkg::DistW-1:0] num,
	input  logic [btc_pkg::DistW:0] den,
	output logic busy,
	output logic [16:0] quo
);
	import btc_pkg::*;

	// remainder stays below den, one quotient bit per cycle
	logic [DistW+1:0] rem_q;
	logic [DistW:0] den_q;
	logic [4:0] cnt_q;
	logic [16:0] quo_q;
	logic [DistW+1:0] trial;
	logic [DistW+1:0] shifted;

	always_comb begin
		shifted = {rem_q[DistW:0], 1'b0};
		trial = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd17;
		end else if (cnt_q != 5'd0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	// first step handles the integer bit, 16 more give the fraction
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {2'b00, num};
			den_q <= den;
			quo_q <= '0;
		end else if (cnt_q == 5'd17) begin
			if ({1'b0, rem_q} >= {2'b00, den_q}) begin
				rem_q <= rem_q - {1'b0, den_q};
				quo_q <= 17'd1;
			end
		end else if (cnt_q != 5'd0) begin
			if (!trial[DistW+1]) begin
				rem_q <= trial;
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[15:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 5'd0) || start;
	assign quo = quo_q;
endmodule
